@@ rtl/gis_pkg.sv @@
// ----------------------------------------------------------------------------
// gis_pkg
// Shared types and constants for the greedy interval selection block.
// ----------------------------------------------------------------------------
`default_nettype none

package gis_pkg;

  localparam int MAX_INTERVALS_DEF = 64;
  localparam int TIME_W            = 9;
  localparam int TAG_W             = 7;
  localparam int TOTAL_W           = 7;
  localparam int ENTRY_W           = 2 * TIME_W + TAG_W;

  typedef struct packed {
    logic [TAG_W-1:0]  tag;
    logic [TIME_W-1:0] iend;
    logic [TIME_W-1:0] istart;
  } entry_t;

endpackage

`default_nettype wire

@@ rtl/greedy_interval_selection.sv @@
// ----------------------------------------------------------------------------
// greedy_interval_selection
// Earliest-finish greedy activity selection over a loaded set of intervals.
// ----------------------------------------------------------------------------
// Intervals are loaded one beat at a time and kept in an on-chip store
// ordered by end time (equal ends keep arrival order). A load into an empty
// store is written directly; otherwise it is accepted, every stored entry
// with a later end is shifted up one place and the new interval is then
// written in place; loads into a full store are dropped and flagged. The
// beat with tlast set starts selection: the store is walked twice through
// its single read port, first to count the picks and then to emit them,
// and the emitting walk holds while the output stalls. Each result beat
// carries the run's total pick count; the store is empty again after the
// last entry has been walked.
// ----------------------------------------------------------------------------
`default_nettype none

module greedy_interval_selection
  import gis_pkg::*;
#(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // interval_start, interval_end, task_tag, zero pad
  input  wire logic        in_tlast,   // final_item
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // chosen_tag, chosen_start, chosen_end, chosen_total
  output logic             out_tuser,  // dropped_flag
  output logic             out_tlast   // run_last
);

  localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;

  entry_t               in_entry;
  entry_t               out_entry;
  logic [TOTAL_W-1:0]   out_total;
  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  entry_t               mem_wdata;
  logic [AW-1:0]        mem_raddr;
  entry_t               mem_rdata;

  assign in_entry.istart = in_tdata[8:0];
  assign in_entry.iend   = in_tdata[17:9];
  assign in_entry.tag    = in_tdata[24:18];

  gis_seq #(
    .MAX_INTERVALS(MAX_INTERVALS)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .in_entry    (in_entry),
    .in_final    (in_tlast),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_entry   (out_entry),
    .out_total   (out_total),
    .out_dropped (out_tuser),
    .out_last    (out_tlast),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  gis_mem #(
    .MAX_INTERVALS(MAX_INTERVALS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_tdata = {out_total, out_entry.iend, out_entry.istart, out_entry.tag};

endmodule

`default_nettype wire

@@ rtl/gis_mem.sv @@
// ----------------------------------------------------------------------------
// gis_mem
// Interval store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gis_mem
  import gis_pkg::*;
#(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
  localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire entry_t        wdata,
  input  wire logic [AW-1:0] raddr,
  output entry_t             rdata
);

  entry_t mem [MAX_INTERVALS];
  entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

@@ rtl/gis_seq.sv @@
// ----------------------------------------------------------------------------
// gis_seq
// Sequencer: ordered insertion into the store, then a counting walk and an
// emitting walk over it, with the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module gis_seq
  import gis_pkg::*;
#(
  parameter int MAX_INTERVALS = MAX_INTERVALS_DEF,
  localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1,
  localparam int CW = $clog2(MAX_INTERVALS + 1)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // input beat
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire entry_t             in_entry,
  input  wire logic               in_final,
  // result beat
  output logic                    out_valid,
  input  wire logic               out_ready,
  output entry_t                  out_entry,
  output logic [TOTAL_W-1:0]      out_total,
  output logic                    out_dropped,
  output logic                    out_last,
  // store port
  output logic                    mem_we,
  output logic [AW-1:0]           mem_waddr,
  output entry_t                  mem_wdata,
  output logic [AW-1:0]           mem_raddr,
  input  wire entry_t             mem_rdata
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_INS  = 5'b00010,
    S_PUT  = 5'b00100,
    S_RD   = 5'b01000,
    S_EV   = 5'b10000
  } state_t;

  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic [AW-1:0]     pos_r, pos_nxt;
  entry_t            new_r, new_nxt;
  logic              fin_r, fin_nxt;
  logic [AW-1:0]     ridx_r, ridx_nxt;
  logic              pass_r, pass_nxt;
  logic              have_r, have_nxt;
  logic [TIME_W-1:0] lend_r, lend_nxt;
  logic [CW-1:0]     n_r, n_nxt;
  logic [CW-1:0]     k_r, k_nxt;
  logic              ov_r, ov_nxt;
  entry_t            oe_r, oe_nxt;
  logic [TOTAL_W-1:0] ot_r, ot_nxt;
  logic              odrop_r, odrop_nxt;
  logic              olast_r, olast_nxt;

  logic              accept;
  logic              out_free;
  logic              pick;
  logic              last_entry;

  assign accept     = in_valid && in_ready;
  assign out_free   = !ov_r || out_ready;
  assign pick       = !have_r || (mem_rdata.istart >= lend_r);
  assign last_entry = (CW'(ridx_r) == count_r - CW'(1));

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    pos_nxt   = pos_r;
    new_nxt   = new_r;
    fin_nxt   = fin_r;
    ridx_nxt  = ridx_r;
    pass_nxt  = pass_r;
    have_nxt  = have_r;
    lend_nxt  = lend_r;
    n_nxt     = n_r;
    k_nxt     = k_r;
    ov_nxt    = ov_r && !out_ready;
    oe_nxt    = oe_r;
    ot_nxt    = ot_r;
    odrop_nxt = odrop_r;
    olast_nxt = olast_r;
    mem_we    = 1'b0;
    mem_waddr = pos_r;
    mem_wdata = new_r;
    mem_raddr = ridx_r;

    case (state_r)
      S_IDLE: begin
        mem_raddr = AW'(count_r - CW'(1));
        if (accept) begin
          new_nxt = in_entry;
          fin_nxt = in_final;
          if (count_r == CW'(MAX_INTERVALS)) begin
            ovf_nxt = 1'b1;
            if (in_final) begin
              ridx_nxt  = '0;
              pass_nxt  = 1'b0;
              have_nxt  = 1'b0;
              n_nxt     = '0;
              k_nxt     = '0;
              state_nxt = S_RD;
            end
          end else if (count_r == '0) begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = in_entry;
            count_nxt = CW'(1);
            if (in_final) begin
              ridx_nxt  = '0;
              pass_nxt  = 1'b0;
              have_nxt  = 1'b0;
              n_nxt     = '0;
              k_nxt     = '0;
              state_nxt = S_RD;
            end
          end else begin
            pos_nxt   = AW'(count_r);
            state_nxt = S_INS;
          end
        end
      end

      S_INS: begin
        mem_raddr = pos_r - AW'(1) - AW'(1);
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        if (mem_rdata.iend > new_r.iend) begin
          mem_wdata = mem_rdata;
          pos_nxt   = pos_r - AW'(1);
          if (pos_r == AW'(1)) begin
            state_nxt = S_PUT;
          end
        end else begin
          mem_wdata = new_r;
          count_nxt = count_r + CW'(1);
          if (fin_r) begin
            ridx_nxt  = '0;
            pass_nxt  = 1'b0;
            have_nxt  = 1'b0;
            n_nxt     = '0;
            k_nxt     = '0;
            state_nxt = S_RD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      S_PUT: begin
        mem_we    = 1'b1;
        mem_waddr = pos_r;
        mem_wdata = new_r;
        count_nxt = count_r + CW'(1);
        if (fin_r) begin
          ridx_nxt  = '0;
          pass_nxt  = 1'b0;
          have_nxt  = 1'b0;
          n_nxt     = '0;
          k_nxt     = '0;
          state_nxt = S_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end

      S_RD: begin
        state_nxt = S_EV;
      end

      S_EV: begin
        if (!(pass_r && pick && !out_free)) begin
          if (pick) begin
            have_nxt = 1'b1;
            lend_nxt = mem_rdata.iend;
            if (!pass_r) begin
              n_nxt = n_r + CW'(1);
            end else begin
              k_nxt     = k_r + CW'(1);
              ov_nxt    = 1'b1;
              oe_nxt    = mem_rdata;
              ot_nxt    = TOTAL_W'(n_r);
              odrop_nxt = ovf_r;
              olast_nxt = (k_r + CW'(1) == n_r);
            end
          end
          if (last_entry) begin
            if (!pass_r) begin
              pass_nxt  = 1'b1;
              ridx_nxt  = '0;
              have_nxt  = 1'b0;
              state_nxt = S_RD;
            end else begin
              count_nxt = '0;
              ovf_nxt   = 1'b0;
              state_nxt = S_IDLE;
            end
          end else begin
            ridx_nxt  = ridx_r + AW'(1);
            state_nxt = S_RD;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      ovf_r   <= 1'b0;
      pass_r  <= 1'b0;
      have_r  <= 1'b0;
      n_r     <= '0;
      k_r     <= '0;
      ov_r    <= 1'b0;
      fin_r   <= 1'b0;
      pos_r   <= '0;
      ridx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      pass_r  <= pass_nxt;
      have_r  <= have_nxt;
      n_r     <= n_nxt;
      k_r     <= k_nxt;
      ov_r    <= ov_nxt;
      fin_r   <= fin_nxt;
      pos_r   <= pos_nxt;
      ridx_r  <= ridx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    new_r   <= new_nxt;
    lend_r  <= lend_nxt;
    oe_r    <= oe_nxt;
    ot_r    <= ot_nxt;
    odrop_r <= odrop_nxt;
    olast_r <= olast_nxt;
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = ov_r;
  assign out_entry   = oe_r;
  assign out_total   = ot_r;
  assign out_dropped = odrop_r;
  assign out_last    = olast_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_INTERVALS))
    else $error("store count beyond capacity");

  a_ins_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |-> (pos_r != '0))
    else $error("shift position reached zero while shifting");

  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pass_r |-> (k_r <= n_r))
    else $error("more beats emitted than counted");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD || state_r == S_EV) |-> (count_r != '0))
    else $error("selection walk over an empty store");

endmodule

`default_nettype wire
